@@ rtl/q2e_pkg.sv @@
// ----------------------------------------------------------------------------
// q2e_pkg: shared constants for the quaternion to Euler angle converter
// Angle accumulator format and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package q2e_pkg;

  // angle accumulator: units of 2^-32 turn, signed, with headroom
  localparam int ZW = 34;
  // guard bits added to the atan2 operands before the rotations
  localparam int GUARD_BITS = 16;
  localparam int TAB_DEPTH = 32;

  localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'sd2147483648);
  localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TAB [TAB_DEPTH] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

@@ rtl/q2e_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// q2e_sqrt_cell: one step of a pipelined restoring square root
// Tries one result bit against the remainder and registers the pair.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell #(
  parameter int VW    = 30,
  parameter int SHIFT = 0
) (
  input  logic          clk,
  input  logic [VW-1:0] v_in,
  input  logic [VW-1:0] r_in,
  output logic [VW-1:0] v_out,
  output logic [VW-1:0] r_out
);

  localparam logic [VW-1:0] BIT = VW'(1) << SHIFT;

  logic [VW-1:0] trial;

  assign trial = r_in + BIT;

  // subtract when the trial fits, shift the root either way
  always_ff @(posedge clk) begin
    if (v_in >= trial) begin
      v_out <= v_in - trial;
      r_out <= (r_in >> 1) + BIT;
    end else begin
      v_out <= v_in;
      r_out <= r_in >> 1;
    end
  end

endmodule

@@ rtl/q2e_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// q2e_cordic_cell: one vectoring CORDIC micro-rotation
// Rotates (x, y) toward the x axis by atan(2^-I) and tracks the angle.
// ----------------------------------------------------------------------------
module q2e_cordic_cell
  import q2e_pkg::*;
#(
  parameter int XW = 40,
  parameter int I  = 0
) (
  input  logic                 clk,
  input  logic                 fixed_in,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic                 fixed_out,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out
);

  localparam logic signed [ZW-1:0] STEP = ZW'(ATAN_TAB[I]);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;

  assign xs = x_in >>> I;
  assign ys = y_in >>> I;

  // a fixed angle (axis case) just rides through
  always_ff @(posedge clk) begin
    fixed_out <= fixed_in;
    if (fixed_in) begin
      x_out <= x_in;
      y_out <= y_in;
      z_out <= z_in;
    end else if (!y_in[XW-1]) begin
      x_out <= x_in + ys;
      y_out <= y_in - xs;
      z_out <= z_in + STEP;
    end else begin
      x_out <= x_in - ys;
      y_out <= y_in + xs;
      z_out <= z_in - STEP;
    end
  end

endmodule

@@ rtl/q2e_atan2.sv @@
// ----------------------------------------------------------------------------
// q2e_atan2: pipelined atan2 as a row of CORDIC cells
// Axis handling and half-plane fold, N micro-rotations, then rounding.
// ----------------------------------------------------------------------------
module q2e_atan2
  import q2e_pkg::*;
#(
  parameter int TW         = 20,
  parameter int AW         = 16,
  parameter int N          = 16,
  parameter bit HALF_RANGE = 1'b0
) (
  input  logic                 clk,
  input  logic signed [TW-1:0] y_in,
  input  logic signed [TW-1:0] x_in,
  output logic signed [AW-1:0] angle
);

  localparam int XW = TW + GUARD_BITS + 3;
  localparam int S  = 32 - AW;
  localparam logic signed [ZW-1:0] RND = ZW'((ZW'(1) << S) >> 1);

  logic signed [XW-1:0] xg;
  logic signed [XW-1:0] yg;
  logic signed [XW-1:0] cx [0:N];
  logic signed [XW-1:0] cy [0:N];
  logic signed [ZW-1:0] cz [0:N];
  logic                 cf [0:N];
  logic signed [ZW-1:0] zc;
  logic signed [ZW-1:0] zr;

  assign xg = XW'(x_in) <<< GUARD_BITS;
  assign yg = XW'(y_in) <<< GUARD_BITS;

  // entry: axis cases and fold into the right half plane
  always_ff @(posedge clk) begin
    if (y_in == '0) begin
      cx[0] <= xg;
      cy[0] <= yg;
      cf[0] <= 1'b1;
      cz[0] <= x_in[TW-1] ? -HALF_TURN : '0;
    end else if (x_in == '0) begin
      cx[0] <= xg;
      cy[0] <= yg;
      cf[0] <= 1'b1;
      cz[0] <= y_in[TW-1] ? -QUARTER_TURN : QUARTER_TURN;
    end else if (x_in[TW-1]) begin
      cx[0] <= -xg;
      cy[0] <= -yg;
      cf[0] <= 1'b0;
      cz[0] <= y_in[TW-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      cx[0] <= xg;
      cy[0] <= yg;
      cf[0] <= 1'b0;
      cz[0] <= '0;
    end
  end

  // micro-rotation row
  for (genvar i = 0; i < N; i++) begin : g_cell
    q2e_cordic_cell #(.XW(XW), .I(i)) u_cell (
      .clk      (clk),
      .fixed_in (cf[i]),
      .x_in     (cx[i]),
      .y_in     (cy[i]),
      .z_in     (cz[i]),
      .fixed_out(cf[i+1]),
      .x_out    (cx[i+1]),
      .y_out    (cy[i+1]),
      .z_out    (cz[i+1])
    );
  end

  // optional quarter-turn clamp, then round half up to AW bits
  always_comb begin
    zc = cz[N];
    if (HALF_RANGE) begin
      if (cz[N] > QUARTER_TURN) zc = QUARTER_TURN;
      if (cz[N] < -QUARTER_TURN) zc = -QUARTER_TURN;
    end
    zr = zc + RND;
  end

  always_ff @(posedge clk) begin
    angle <= $signed(zr[S +: AW]);
  end

endmodule

@@ rtl/quaternion_to_euler_angles_top.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top: unit quaternion to roll, pitch and yaw
// Products and sums, pitch cosine by square root, three CORDIC rows.
// ----------------------------------------------------------------------------
// Takes one quaternion word per clock (busy stays low) and returns roll,
// pitch and yaw as binary angles with done high for one cycle; results
// leave in the order taken. The receiver cannot stall the block: each result
// word must be taken in the one cycle that done marks. The path runs through
// the square-root row (one cell per root bit) that forms the pitch cosine,
// then the CORDIC row (one cell per micro-rotation) and the rounding register.
module quaternion_to_euler_angles_top
  import q2e_pkg::*;
#(
  parameter int COMPONENT_WIDTH = 16,
  parameter int ANGLE_WIDTH     = 16,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_x,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_y,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_z,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_w,
  output logic                           done,
  output logic signed [ANGLE_WIDTH-1:0]  roll_angle,
  output logic signed [ANGLE_WIDTH-1:0]  pitch_angle,
  output logic signed [ANGLE_WIDTH-1:0]  yaw_angle
);

  localparam int CW  = COMPONENT_WIDTH;
  localparam int F   = CW - 2;
  localparam int PW  = CW + 2;
  localparam int TW  = CW + 4;
  localparam int VW  = 2 * F + 2;
  localparam int DLY = F + 3;
  localparam int LAT = F + CORDIC_STAGES + 7;
  localparam logic signed [TW-1:0] ONE = TW'(1) <<< F;
  localparam logic signed [TW-1:0] MONE = -ONE;

  logic signed [2*CW-1:0] m_wx, m_yz, m_xx, m_yy, m_wy, m_zx, m_wz, m_xy, m_zz;
  logic signed [PW-1:0]   p_wx, p_yz, p_xx, p_yy, p_wy, p_zx, p_wz, p_xy, p_zz;
  logic signed [TW-1:0]   s2;
  logic signed [TW-1:0]   t0, t1, t2, t3, t4;
  logic signed [TW-1:0]   d0 [0:DLY-1];
  logic signed [TW-1:0]   d1 [0:DLY-1];
  logic signed [TW-1:0]   d2 [0:DLY-1];
  logic signed [TW-1:0]   d3 [0:DLY-1];
  logic signed [TW-1:0]   d4 [0:DLY-1];
  logic signed [F+1:0]    sm;
  logic signed [2*F+3:0]  sq_full;
  logic [2*F:0]           sq;
  logic [VW-1:0]          sv [0:F+1];
  logic [VW-1:0]          sr [0:F+1];
  logic signed [TW-1:0]   cosv;
  logic [LAT-1:0]         vld;

  assign busy = 1'b0;

  // products, floor-scaled back to F fraction bits
  assign m_wx = quat_w * quat_x;
  assign m_yz = quat_y * quat_z;
  assign m_xx = quat_x * quat_x;
  assign m_yy = quat_y * quat_y;
  assign m_wy = quat_w * quat_y;
  assign m_zx = quat_z * quat_x;
  assign m_wz = quat_w * quat_z;
  assign m_xy = quat_x * quat_y;
  assign m_zz = quat_z * quat_z;

  always_ff @(posedge clk) begin
    p_wx <= $signed(m_wx[2*CW-1:F]);
    p_yz <= $signed(m_yz[2*CW-1:F]);
    p_xx <= $signed(m_xx[2*CW-1:F]);
    p_yy <= $signed(m_yy[2*CW-1:F]);
    p_wy <= $signed(m_wy[2*CW-1:F]);
    p_zx <= $signed(m_zx[2*CW-1:F]);
    p_wz <= $signed(m_wz[2*CW-1:F]);
    p_xy <= $signed(m_xy[2*CW-1:F]);
    p_zz <= $signed(m_zz[2*CW-1:F]);
  end

  // atan2 operands; pitch sine clamped to one
  assign s2 = (TW'(p_wy) - TW'(p_zx)) <<< 1;

  always_ff @(posedge clk) begin
    t0 <= (TW'(p_wx) + TW'(p_yz)) <<< 1;
    t1 <= ONE - ((TW'(p_xx) + TW'(p_yy)) <<< 1);
    t3 <= (TW'(p_wz) + TW'(p_xy)) <<< 1;
    t4 <= ONE - ((TW'(p_yy) + TW'(p_zz)) <<< 1);
    if (s2 > ONE) t2 <= ONE;
    else if (s2 < MONE) t2 <= MONE;
    else t2 <= s2;
  end

  // operands wait here while the cosine is formed
  always_ff @(posedge clk) begin
    d0[0] <= t0;
    d1[0] <= t1;
    d2[0] <= t2;
    d3[0] <= t3;
    d4[0] <= t4;
    for (int k = 1; k < DLY; k++) begin
      d0[k] <= d0[k-1];
      d1[k] <= d1[k-1];
      d2[k] <= d2[k-1];
      d3[k] <= d3[k-1];
      d4[k] <= d4[k-1];
    end
  end

  // one minus sine squared
  assign sm      = t2[F+1:0];
  assign sq_full = sm * sm;

  always_ff @(posedge clk) begin
    sq    <= sq_full[2*F:0];
    sv[0] <= (VW'(1) << (2 * F)) - VW'(sq);
    sr[0] <= '0;
  end

  // square-root row, one root bit per cell
  for (genvar k = 0; k <= F; k++) begin : g_sqrt
    q2e_sqrt_cell #(.VW(VW), .SHIFT(2 * (F - k))) u_cell (
      .clk  (clk),
      .v_in (sv[k]),
      .r_in (sr[k]),
      .v_out(sv[k+1]),
      .r_out(sr[k+1])
    );
  end

  assign cosv = TW'(sr[F+1][F+1:0]);

  // three angle rows
  q2e_atan2 #(.TW(TW), .AW(ANGLE_WIDTH), .N(CORDIC_STAGES), .HALF_RANGE(1'b0)) u_roll (
    .clk  (clk),
    .y_in (d0[DLY-1]),
    .x_in (d1[DLY-1]),
    .angle(roll_angle)
  );

  q2e_atan2 #(.TW(TW), .AW(ANGLE_WIDTH), .N(CORDIC_STAGES), .HALF_RANGE(1'b1)) u_pitch (
    .clk  (clk),
    .y_in (d2[DLY-1]),
    .x_in (cosv),
    .angle(pitch_angle)
  );

  q2e_atan2 #(.TW(TW), .AW(ANGLE_WIDTH), .N(CORDIC_STAGES), .HALF_RANGE(1'b0)) u_yaw (
    .clk  (clk),
    .y_in (d3[DLY-1]),
    .x_in (d4[DLY-1]),
    .angle(yaw_angle)
  );

  // word tracking along the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start};
    end
  end

  assign done = vld[LAT-1];

`ifndef SYNTHESIS
  localparam logic signed [ANGLE_WIDTH-1:0] QTR = ANGLE_WIDTH'(1) <<< (ANGLE_WIDTH - 2);

  a_done_has_word: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result strobe without a word taken");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (pitch_angle <= QTR && pitch_angle >= -QTR))
    else $error("pitch beyond a quarter turn");

  a_identity: assert property (@(posedge clk) disable iff (rst)
    (start && quat_x == '0 && quat_y == '0 && quat_z == '0) |-> ##LAT
      (done && roll_angle == '0 && pitch_angle == '0 && yaw_angle == '0))
    else $error("pure scalar quaternion gave nonzero angles");
`endif

endmodule

@@ tb/quaternion_to_euler_angles_top_test.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top_test: self-checking bench for the converter
// Feeds quaternion words with random gaps, predicts roll, pitch and yaw
// with a bit-exact CORDIC predictor and checks every result word in order.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_top_test;
  import q2e_pkg::*;

  localparam int CW = 16;
  localparam int AW = 16;
  localparam int STAGES = 16;
  localparam int FB = CW - 2;
  localparam int LATENCY = FB + STAGES + 7;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] w;
  } quat_t;

  typedef struct packed {
    logic signed [AW-1:0] roll;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] yaw;
  } euler_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [CW-1:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
  logic done;
  logic signed [AW-1:0] roll_angle, pitch_angle, yaw_angle;

  quat_t pending_quats[$];
  euler_t expected_angles[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  bit stimulus_done = 1'b0;

  quaternion_to_euler_angles_top #(
    .COMPONENT_WIDTH(CW), .ANGLE_WIDTH(AW), .CORDIC_STAGES(STAGES)
  ) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .done(done), .roll_angle(roll_angle), .pitch_angle(pitch_angle),
    .yaw_angle(yaw_angle)
  );

  always #1 clk = ~clk;

  // fixed-point product, floor shift back to FB fraction bits
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> FB;
  endfunction

  // vectoring CORDIC atan2, result in 2^-32 turn
  function automatic longint atan2_turns(longint yv, longint xv);
    longint acc, xs, ys;
    acc = 0;
    if (yv == 0) return (xv < 0) ? -(64'sd1 <<< 31) : 0;
    if (xv == 0) return (yv > 0) ? (64'sd1 <<< 30) : -(64'sd1 <<< 30);
    xv = xv <<< GUARD_BITS;
    yv = yv <<< GUARD_BITS;
    if (xv < 0) begin
      acc = (yv >= 0) ? (64'sd1 <<< 31) : -(64'sd1 <<< 31);
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < STAGES; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv >= 0) begin
        xv += ys; yv -= xs; acc += longint'(ATAN_TAB[i]);
      end else begin
        xv -= ys; yv += xs; acc -= longint'(ATAN_TAB[i]);
      end
    end
    return acc;
  endfunction

  // round half up to AW bits, wrap
  function automatic logic signed [AW-1:0] turns_to_angle(longint t);
    return AW'((t + (64'sd1 <<< (31 - AW))) >>> (32 - AW));
  endfunction

  // bit-by-bit floor root; the top trial bit keeps every square in range
  function automatic longint floor_sqrt(longint v);
    longint r;
    r = 0;
    for (longint b = 64'sd1 <<< 30; b > 0; b = b >>> 1)
      if ((r + b) * (r + b) <= v) r += b;
    return r;
  endfunction

  function automatic euler_t predict_angles(quat_t q);
    longint x, y, z, w, one, ysq, sr, cr, sp, cp, sy, cy, p;
    euler_t e;
    x = q.x; y = q.y; z = q.z; w = q.w;
    one = 64'sd1 <<< FB;
    ysq = fx_mul(y, y);
    sr = 2 * (fx_mul(w, x) + fx_mul(y, z));
    cr = one - 2 * (fx_mul(x, x) + ysq);
    sp = 2 * (fx_mul(w, y) - fx_mul(z, x));
    sy = 2 * (fx_mul(w, z) + fx_mul(x, y));
    cy = one - 2 * (ysq + fx_mul(z, z));
    if (sp > one) sp = one;
    if (sp < -one) sp = -one;
    cp = floor_sqrt(one * one - sp * sp);
    p = atan2_turns(sp, cp);
    if (p > (64'sd1 <<< 30)) p = 64'sd1 <<< 30;
    if (p < -(64'sd1 <<< 30)) p = -(64'sd1 <<< 30);
    e.roll = turns_to_angle(atan2_turns(sr, cr));
    e.pitch = turns_to_angle(p);
    e.yaw = turns_to_angle(atan2_turns(sy, cy));
    return e;
  endfunction

  function automatic logic signed [CW-1:0] rand_comp();
    return CW'($urandom_range(32768) - 16384);
  endfunction

  function automatic quat_t make_quat(int a, int b, int c, int d);
    quat_t q;
    q.x = CW'(a); q.y = CW'(b); q.z = CW'(c); q.w = CW'(d);
    return q;
  endfunction

  // directed and random stimulus
  initial begin
    int h, s;
    quat_t q;
    pending_quats.push_back(make_quat(0, 0, 0, 16384));
    pending_quats.push_back(make_quat(0, 0, 0, -16384));
    pending_quats.push_back(make_quat(16384, 0, 0, 0));
    pending_quats.push_back(make_quat(0, 16384, 0, 0));
    pending_quats.push_back(make_quat(0, 0, 16384, 0));
    pending_quats.push_back(make_quat(0, 0, 0, 0));
    pending_quats.push_back(make_quat(-16384, -16384, -16384, -16384));
    pending_quats.push_back(make_quat(16384, 16384, 16384, 16384));
    pending_quats.push_back(make_quat(-16384, 16384, -16384, 16384));
    pending_quats.push_back(make_quat(11585, 0, 0, 11585));
    pending_quats.push_back(make_quat(0, 11585, 0, 11585));
    pending_quats.push_back(make_quat(0, -11585, 0, 11585));
    pending_quats.push_back(make_quat(0, 0, 11585, 11585));
    pending_quats.push_back(make_quat(8192, 8192, 8192, 8192));
    pending_quats.push_back(make_quat(-8192, 8192, 8192, 8192));
    pending_quats.push_back(make_quat(11586, 0, 0, 0));
    pending_quats.push_back(make_quat(0, 11586, 0, -11586));
    pending_quats.push_back(make_quat(1, -1, 1, -1));
    pending_quats.push_back(make_quat(-32768, 32767, -32768, 32767));
    pending_quats.push_back(make_quat(32767, -32768, 32767, -32768));
    pending_quats.push_back(make_quat(-21846, 5461, -1, 16384));
    for (int n = 0; n < 850; n++) begin
      if (n % 5 == 0) begin
        // full 16-bit raw patterns, off the unit sphere
        q = quat_t'({$urandom, $urandom});
      end else if (n % 5 == 1) begin
        // near gimbal lock: w*y - z*x close to +-0.5
        h = $urandom_range(16384);
        s = $urandom_range(1) ? 11585 : -11585;
        q = make_quat(h % 64 - 32, s + int'($urandom_range(64)) - 32, h % 32, 11585);
      end else begin
        q = make_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      end
      pending_quats.push_back(q);
    end
  end

  // driver: one word per handshake, random gaps
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // word held until accepted
    end else begin
      if (start) begin
        expected_angles.push_back(predict_angles({quat_x, quat_y, quat_z, quat_w}));
        words_sent <= words_sent + 1;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_quats.size() > 0) begin
        quat_t q;
        q = pending_quats.pop_front();
        quat_x <= q.x; quat_y <= q.y; quat_z <= q.z; quat_w <= q.w;
        start <= 1'b1;
        gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(18);
      end else begin
        start <= 1'b0;
        stimulus_done <= 1'b1;
      end
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_angles.size() == 0) begin
        $display("%0t: result word with no prediction: roll %0d pitch %0d yaw %0d",
                 $time, roll_angle, pitch_angle, yaw_angle);
        errors++;
      end else begin
        euler_t e;
        e = expected_angles.pop_front();
        if (roll_angle !== e.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time, e.roll, roll_angle);
          errors++;
        end
        if (pitch_angle !== e.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, pitch_angle);
          errors++;
        end
        if (yaw_angle !== e.yaw) begin
          $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, yaw_angle);
          errors++;
        end
        words_checked++;
      end
    end
  end

  // reset, drain, verdict
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait (stimulus_done && expected_angles.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d quaternions (axis, gimbal-lock, full-range and random);",
             words_sent);
    $display("checked %0d roll/pitch/yaw words.", words_checked);
    if (errors == 0 && expected_angles.size() == 0) begin
      $display("PASS quaternion_to_euler_angles_top");
    end else begin
      $display("FAIL quaternion_to_euler_angles_top");
    end
    $finish;
  end

  // run limit
  initial begin
    #200000;
    $display("FAIL quaternion_to_euler_angles_top");
    $finish;
  end

endmodule
